[src/emgact_pkg.sv]
// shared constants, register codes and types for the emg activation block
`timescale 1ns / 1ps

package emgact_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 18;
  localparam int POLE_W     = 18;
  localparam int SHAPE_W    = 19;
  localparam int RECIP_W    = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_POLE_ONE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_TWO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_FACTOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_RECIP   = 2'd3;

  // serial multiplier: multiplier operand width and digit count width
  localparam int MUL_B_W = 32;
  localparam int DIG_W   = 5;

  // log2(e) in q30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIG_W-1:0] ndig;
  } emgact_mul_ctl_t;

endpackage

[src/emgact_mul.sv]
// radix-4 digit-serial magnitude multiplier with sign applied at the output
`timescale 1ns / 1ps

module emgact_mul import emgact_pkg::*; #(
  parameter int A_W = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  emgact_mul_ctl_t              ctl,
  input  logic [A_W-1:0]               a_mag,
  input  logic [MUL_B_W-1:0]           b_al,
  output logic                         done,
  output logic signed [A_W+MUL_B_W:0]  prod
);

  localparam int P_W = A_W + MUL_B_W;

  logic [P_W-1:0]     acc_r;
  logic [P_W-1:0]     acc_nxt;
  logic [P_W-1:0]     addend;
  logic [MUL_B_W-1:0] b_r;
  logic [A_W-1:0]     a_r;
  logic [A_W+1:0]     a3_r;
  logic [DIG_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic               neg_r;
  logic [1:0]         digit;

  // msb-first: acc = 4*acc + digit*a
  always_comb begin
    digit = b_r[MUL_B_W-1 -: 2];
    unique case (digit)
      2'd0:    addend = '0;
      2'd1:    addend = P_W'(a_r);
      2'd2:    addend = P_W'({a_r, 1'b0});
      default: addend = P_W'(a3_r);
    endcase
    acc_nxt = (acc_r << 2) + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == DIG_W'(1));
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == DIG_W'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
      b_r   <= b_al;
      a_r   <= a_mag;
      a3_r  <= (A_W+2)'(a_mag) + (A_W+2)'({a_mag, 1'b0});
      cnt_r <= ctl.ndig;
      neg_r <= ctl.neg;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << 2;
      cnt_r <= cnt_r - DIG_W'(1);
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

endmodule

[src/emgact_pow2_rom.sv]
// table of 2^(k/depth) in q30 with registered read
`timescale 1ns / 1ps

module emgact_pow2_rom import emgact_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  output logic [31:0]   data
);

  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // truncated taylor series of exp(k*ln2/depth), through the z^24 term
  function automatic logic [31:0] pow2_entry(input int k);
    longint unsigned z;
    longint unsigned t;
    longint unsigned s;
    z = longint'(k) * LN2_Q30 / DEPTH;
    t = ONE_Q30;
    s = ONE_Q30;
    t = ((t * z) >> 30) / 1;  s += t;  t = ((t * z) >> 30) / 2;  s += t;
    t = ((t * z) >> 30) / 3;  s += t;  t = ((t * z) >> 30) / 4;  s += t;
    t = ((t * z) >> 30) / 5;  s += t;  t = ((t * z) >> 30) / 6;  s += t;
    t = ((t * z) >> 30) / 7;  s += t;  t = ((t * z) >> 30) / 8;  s += t;
    t = ((t * z) >> 30) / 9;  s += t;  t = ((t * z) >> 30) / 10; s += t;
    t = ((t * z) >> 30) / 11; s += t;  t = ((t * z) >> 30) / 12; s += t;
    t = ((t * z) >> 30) / 13; s += t;  t = ((t * z) >> 30) / 14; s += t;
    t = ((t * z) >> 30) / 15; s += t;  t = ((t * z) >> 30) / 16; s += t;
    t = ((t * z) >> 30) / 17; s += t;  t = ((t * z) >> 30) / 18; s += t;
    t = ((t * z) >> 30) / 19; s += t;  t = ((t * z) >> 30) / 20; s += t;
    t = ((t * z) >> 30) / 21; s += t;  t = ((t * z) >> 30) / 22; s += t;
    t = ((t * z) >> 30) / 23; s += t;  t = ((t * z) >> 30) / 24; s += t;
    return s[31:0];
  endfunction

  logic [31:0] tab [0:DEPTH];
  logic [31:0] data_r;

  for (genvar g = 0; g <= DEPTH; g++) begin : g_tab
    assign tab[g] = pow2_entry(g);
  end

  always_ff @(posedge clk) begin
    data_r <= tab[addr];
  end

  assign data = data_r;

endmodule

[src/emg_exponential_activation.sv]
// top level: emg sample to muscle activation through a serial fixed-point datapath
`timescale 1ns / 1ps
// usage
//   input channel in_valid/in_ready carries one emg sample (signed q2.14) and a
//   restart flag; restart clears the filter and sample history before the sample
//   output channel out_valid/out_ready returns activation, the filtered neural
//   activation u and an in-range flag for each sample, one result per sample
//   cfg_valid/cfg_ready writes pole_one, pole_two, shape_factor and norm_recip
//   by index; cfg_ready is always high; the user must make writes only while the
//   block is idle, and the block itself does not enforce this
// sequencing
//   eight multiplies run one after another on a shared radix-4 serial
//   multiplier, two multiplier bits per cycle, and six more steps finish the item;
//   a new sample is taken only after the finished item has been handed to the
//   result register
// reset (rst_n, synchronous) clears the coefficients, the history and the output
//   valid flag; the exp table is constant and needs no fill
// a stalled receiver stops new samples from being taken: the result register
//   holds the old result and the finished item waits in its last step

module emg_exponential_activation import emgact_pkg::*; #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_emg_sample,
  input  logic                        in_restart,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_W-1:0]     out_activation,
  output logic signed [OUT_W-1:0]     out_neural_activation,
  output logic                        out_in_range,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  // widths that follow from the fraction bits and table depth
  localparam int E_W     = FRAC_BITS + 1;                   // clamped sample 0..1
  localparam int NP_W    = (FRAC_BITS + 2 > OUT_W) ? FRAC_BITS + 2 : OUT_W;
  localparam int MUL_A_W = FRAC_BITS + 16;
  localparam int P_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = P_W + 3;
  localparam int OPW     = MUL_A_W + 1;
  localparam int X_W     = FRAC_BITS + 5;
  localparam int Y_W     = FRAC_BITS + 5;
  localparam int AW      = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int POS_W   = FRAC_BITS + AW;
  localparam int M_W     = 33;
  localparam int EXP_W   = FRAC_BITS + 14;
  localparam int SH_UP   = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int SH_DN   = (FRAC_BITS >= 14) ? 0 : 14 - FRAC_BITS;

  // digit counts of the multiplier operand for each multiply
  localparam int DIG_C  = (POLE_W + 1) / 2;
  localparam int DIG_E  = (E_W + 1) / 2;
  localparam int DIG_NP = (NP_W + 1) / 2;
  localparam int DIG_U  = (OUT_W + 1) / 2;
  localparam int DIG_L  = MUL_B_W / 2;
  localparam int DIG_N  = (RECIP_W + 1) / 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] X_HI   = SUM_W'(8) <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] X_LO   = -X_HI;
  localparam logic signed [OPW-1:0]   ONE_OP = OPW'(1) << FRAC_BITS;
  localparam logic signed [EXP_W:0]   ONE_EX = (EXP_W+1)'(1) << FRAC_BITS;
  localparam logic [SAMPLE_W-1:0]     ONE_Q14 = SAMPLE_W'(16384);
  localparam logic [AW-1:0]           K_MAX  = AW'(EXP_TABLE_DEPTH - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_B2   = 4'd1;   // c1*c2
  localparam logic [3:0] ST_AE   = 4'd2;   // alpha*e
  localparam logic [3:0] ST_B1U  = 4'd3;   // beta1*u1
  localparam logic [3:0] ST_B2U  = 4'd4;   // beta2*u2
  localparam logic [3:0] ST_SAT  = 4'd5;   // saturate u
  localparam logic [3:0] ST_AX   = 4'd6;   // A*u
  localparam logic [3:0] ST_Y    = 4'd7;   // x*log2(e)
  localparam logic [3:0] ST_POS  = 4'd8;   // table position
  localparam logic [3:0] ST_RD0  = 4'd9;   // read entry k
  localparam logic [3:0] ST_RD1  = 4'd10;  // read entry k+1
  localparam logic [3:0] ST_MD   = 4'd11;  // interpolation
  localparam logic [3:0] ST_SH   = 4'd12;  // scale by 2^n
  localparam logic [3:0] ST_ACT  = 4'd13;  // (exp-1)*norm_recip
  localparam logic [3:0] ST_DONE = 4'd14;  // hand to result register

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = OUT_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = OUT_W'(SAT_LO);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

  // configuration registers
  logic signed [POLE_W-1:0]  pole_one_r;
  logic signed [POLE_W-1:0]  pole_two_r;
  logic signed [SHAPE_W-1:0] shape_factor_r;
  logic signed [RECIP_W-1:0] norm_recip_r;

  // filter history
  logic signed [NP_W-1:0] np1_r;
  logic signed [NP_W-1:0] np2_r;
  logic [E_W-1:0]         ep1_r;
  logic [E_W-1:0]         ep2_r;
  logic [1:0]             cnt_r;

  // sequencer and working registers
  logic [3:0]              state_r;
  logic                    issued_r;
  logic [E_W-1:0]          e_r;
  logic                    ok_r;
  logic signed [OPW-1:0]   alpha_r;
  logic signed [OPW-1:0]   beta2_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [OUT_W-1:0] u_r;
  logic signed [X_W-1:0]   x_r;
  logic signed [Y_W-1:0]   y_r;
  logic [POS_W-1:0]        pos_r;
  logic [31:0]             t0_r;
  logic [M_W-1:0]          m_r;
  logic signed [EXP_W:0]   expm1_r;
  logic signed [OUT_W-1:0] act_r;

  // result register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_act_r;
  logic signed [OUT_W-1:0] out_u_r;
  logic                    out_ok_r;

  // combinational helpers
  logic                        in_xfer;
  logic                        out_load;
  logic [SAMPLE_W-2:0]         e14;
  logic                        ok_in;
  logic [E_W+14:0]             e_wide;
  logic [E_W-1:0]              e_in;
  logic [E_W-1:0]              mean;
  logic signed [POLE_W:0]      beta1;
  logic signed [SUM_W-1:0]     prod_w;
  logic signed [SUM_W-1:0]     prod_f;
  logic [AW-1:0]               k_idx;
  logic [AW-1:0]               rom_addr;
  logic [31:0]                 rom_data;
  logic signed [4:0]           n_int;
  logic signed [6:0]           sh_amt;
  logic [6:0]                  sh_neg;
  logic [EXP_W+M_W-1:0]        exp_wide;
  logic [EXP_W-1:0]            exp_val;
  logic                        is_op;
  logic                        mul_done;
  logic signed [P_W:0]         mul_prod;
  logic [MUL_A_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]          mul_b;
  emgact_mul_ctl_t             mul_ctl;

  // operand magnitudes
  logic [POLE_W-1:0]  c1_mag;
  logic [POLE_W-1:0]  c2_mag;
  logic [OPW-1:0]     alpha_mag;
  logic [POLE_W:0]    beta1_mag;
  logic [OPW-1:0]     beta2_mag;
  logic [NP_W-1:0]    np1_mag;
  logic [NP_W-1:0]    np2_mag;
  logic [SHAPE_W-1:0] shape_mag;
  logic [OUT_W-1:0]   u_mag;
  logic [X_W-1:0]     x_mag;
  logic [EXP_W:0]     expm1_mag;
  logic [RECIP_W-1:0] recip_mag;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  // clamp the sample to 0..1 and move it to the internal fraction width
  always_comb begin
    ok_in = 1'b1;
    e14   = '0;
    if (in_emg_sample[SAMPLE_W-1]) begin
      ok_in = 1'b0;
    end else if ($unsigned(in_emg_sample) > ONE_Q14) begin
      ok_in = 1'b0;
      e14   = ONE_Q14[SAMPLE_W-2:0];
    end else begin
      e14   = in_emg_sample[SAMPLE_W-2:0];
    end
    e_wide = (E_W+15)'(e14) << SH_UP;
    e_in   = E_W'(e_wide >> SH_DN);
    mean   = E_W'(((E_W+1)'(ep1_r) + (E_W+1)'(ep2_r)) >> 1);
  end

  // signed helpers and magnitudes
  always_comb begin
    beta1     = (POLE_W+1)'(pole_one_r) + (POLE_W+1)'(pole_two_r);
    c1_mag    = pole_one_r[POLE_W-1] ? POLE_W'(-pole_one_r) : POLE_W'(pole_one_r);
    c2_mag    = pole_two_r[POLE_W-1] ? POLE_W'(-pole_two_r) : POLE_W'(pole_two_r);
    alpha_mag = alpha_r[OPW-1] ? OPW'(-alpha_r) : OPW'(alpha_r);
    beta1_mag = beta1[POLE_W] ? (POLE_W+1)'(-beta1) : (POLE_W+1)'(beta1);
    beta2_mag = beta2_r[OPW-1] ? OPW'(-beta2_r) : OPW'(beta2_r);
    np1_mag   = np1_r[NP_W-1] ? NP_W'(-np1_r) : NP_W'(np1_r);
    np2_mag   = np2_r[NP_W-1] ? NP_W'(-np2_r) : NP_W'(np2_r);
    shape_mag = shape_factor_r[SHAPE_W-1] ? SHAPE_W'(-shape_factor_r)
                                          : SHAPE_W'(shape_factor_r);
    u_mag     = u_r[OUT_W-1] ? OUT_W'(-u_r) : OUT_W'(u_r);
    x_mag     = x_r[X_W-1] ? X_W'(-x_r) : X_W'(x_r);
    expm1_mag = expm1_r[EXP_W] ? (EXP_W+1)'(-expm1_r) : (EXP_W+1)'(expm1_r);
    recip_mag = norm_recip_r[RECIP_W-1] ? RECIP_W'(-norm_recip_r)
                                        : RECIP_W'(norm_recip_r);
  end

  // multiplier operand select; the multiplier operand is left aligned
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    mul_ctl.neg  = 1'b0;
    mul_ctl.ndig = '0;
    is_op        = 1'b0;
    unique case (state_r)
      ST_B2: begin
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(c1_mag);
        mul_b        = MUL_B_W'(c2_mag) << (MUL_B_W - 2 * DIG_C);
        mul_ctl.neg  = pole_one_r[POLE_W-1] ^ pole_two_r[POLE_W-1];
        mul_ctl.ndig = DIG_W'(DIG_C);
      end
      ST_AE: begin
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(alpha_mag);
        mul_b        = MUL_B_W'(e_r) << (MUL_B_W - 2 * DIG_E);
        mul_ctl.neg  = alpha_r[OPW-1];
        mul_ctl.ndig = DIG_W'(DIG_E);
      end
      ST_B1U: begin
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(beta1_mag);
        mul_b        = MUL_B_W'(np1_mag) << (MUL_B_W - 2 * DIG_NP);
        mul_ctl.neg  = beta1[POLE_W] ^ np1_r[NP_W-1];
        mul_ctl.ndig = DIG_W'(DIG_NP);
      end
      ST_B2U: begin
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(beta2_mag);
        mul_b        = MUL_B_W'(np2_mag) << (MUL_B_W - 2 * DIG_NP);
        mul_ctl.neg  = beta2_r[OPW-1] ^ np2_r[NP_W-1];
        mul_ctl.ndig = DIG_W'(DIG_NP);
      end
      ST_AX: begin
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(shape_mag);
        mul_b        = MUL_B_W'(u_mag) << (MUL_B_W - 2 * DIG_U);
        mul_ctl.neg  = shape_factor_r[SHAPE_W-1] ^ u_r[OUT_W-1];
        mul_ctl.ndig = DIG_W'(DIG_U);
      end
      ST_Y: begin
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(x_mag);
        mul_b        = MUL_B_W'(LOG2E_Q30) << (MUL_B_W - 2 * DIG_L);
        mul_ctl.neg  = x_r[X_W-1];
        mul_ctl.ndig = DIG_W'(DIG_L);
      end
      ST_MD: begin
        // interpolation weight times the step between neighboring entries
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(pos_r[FRAC_BITS-1:0]);
        mul_b        = MUL_B_W'(rom_data - t0_r) << (MUL_B_W - 2 * DIG_L);
        mul_ctl.ndig = DIG_W'(DIG_L);
      end
      ST_ACT: begin
        is_op        = 1'b1;
        mul_a        = MUL_A_W'(expm1_mag);
        mul_b        = MUL_B_W'(recip_mag) << (MUL_B_W - 2 * DIG_N);
        mul_ctl.neg  = expm1_r[EXP_W] ^ norm_recip_r[RECIP_W-1];
        mul_ctl.ndig = DIG_W'(DIG_N);
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
    mul_ctl.start = is_op && !issued_r;
  end

  emgact_mul #(
    .A_W (MUL_A_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a_mag (mul_a),
    .b_al  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // product scaled back to the fraction width (floor)
  assign prod_w = SUM_W'(mul_prod);
  assign prod_f = prod_w >>> FRAC_BITS;

  // table lookup: k is the top of pos, the low fraction bits weight the step
  always_comb begin
    if (pos_r[POS_W-1:FRAC_BITS] >= AW'(EXP_TABLE_DEPTH)) begin
      k_idx = K_MAX;
    end else begin
      k_idx = pos_r[POS_W-1:FRAC_BITS];
    end
    rom_addr = (state_r == ST_RD0) ? k_idx : k_idx + AW'(1);
  end

  emgact_pow2_rom #(
    .DEPTH (EXP_TABLE_DEPTH),
    .AW    (AW)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // 2^n scaling of the q30 mantissa, n = integer part of y
  always_comb begin
    n_int    = y_r[Y_W-1:FRAC_BITS];
    sh_amt   = {{2{n_int[4]}}, n_int} + 7'(FRAC_BITS - 30);
    sh_neg   = 7'(-sh_amt);
    exp_wide = '0;
    if (!sh_amt[6]) begin
      exp_wide = (EXP_W+M_W)'(m_r) << sh_amt[5:0];
    end else begin
      exp_wide = (EXP_W+M_W)'(m_r >> sh_neg);
    end
    exp_val = EXP_W'(exp_wide);
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_one_r     <= '0;
      pole_two_r     <= '0;
      shape_factor_r <= '0;
      norm_recip_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLE_ONE:     pole_one_r     <= cfg_data[POLE_W-1:0];
        REG_POLE_TWO:     pole_two_r     <= cfg_data[POLE_W-1:0];
        REG_SHAPE_FACTOR: shape_factor_r <= cfg_data[SHAPE_W-1:0];
        REG_NORM_RECIP:   norm_recip_r   <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
      np1_r    <= '0;
      np2_r    <= '0;
      ep1_r    <= '0;
      ep2_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (mul_ctl.start) begin
        issued_r <= 1'b1;
      end else if (mul_done) begin
        issued_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            ep1_r <= e_in;
            if (in_restart) begin
              ep2_r <= '0;
              np1_r <= '0;
              np2_r <= '0;
              cnt_r <= 2'd1;
            end else begin
              ep2_r <= ep1_r;
              if (cnt_r != 2'd3) begin
                cnt_r <= cnt_r + 2'd1;
              end
              // third sample: seed the filter history with the sample mean
              if (cnt_r == 2'd2) begin
                np1_r <= NP_W'(mean);
                np2_r <= NP_W'(mean);
              end
            end
            state_r <= ST_B2;
          end
        end
        ST_B2:   if (mul_done) state_r <= ST_AE;
        ST_AE:   if (mul_done) state_r <= ST_B1U;
        ST_B1U:  if (mul_done) state_r <= ST_B2U;
        ST_B2U:  if (mul_done) state_r <= ST_SAT;
        ST_SAT:  state_r <= ST_AX;
        ST_AX:   if (mul_done) state_r <= ST_Y;
        ST_Y:    if (mul_done) state_r <= ST_POS;
        ST_POS:  state_r <= ST_RD0;
        ST_RD0:  state_r <= ST_RD1;
        ST_RD1:  state_r <= ST_MD;
        ST_MD:   if (mul_done) state_r <= ST_SH;
        ST_SH:   state_r <= ST_ACT;
        ST_ACT:  if (mul_done) state_r <= ST_DONE;
        ST_DONE: begin
          if (out_load) begin
            np2_r   <= np1_r;
            np1_r   <= NP_W'(u_r);
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      e_r  <= e_in;
      ok_r <= ok_in;
    end
    if (mul_done) begin
      unique case (state_r)
        ST_B2: begin
          beta2_r <= OPW'(prod_f);
          alpha_r <= ONE_OP + OPW'(beta1) + OPW'(prod_f);
        end
        ST_AE:  sum_r <= prod_w;
        ST_B1U: sum_r <= sum_r - prod_w;
        ST_B2U: sum_r <= sum_r - prod_w;
        ST_AX: begin
          if (prod_f > X_HI) begin
            x_r <= X_W'(X_HI);
          end else if (prod_f < X_LO) begin
            x_r <= X_W'(X_LO);
          end else begin
            x_r <= X_W'(prod_f);
          end
        end
        ST_Y:   y_r <= Y_W'(prod_w >>> 30);
        ST_MD:  m_r <= M_W'(t0_r) + M_W'(prod_f);
        ST_ACT: act_r <= sat_out(prod_f);
        default: ;
      endcase
    end
    if (state_r == ST_SAT) begin
      u_r <= sat_out(sum_r >>> FRAC_BITS);
    end
    if (state_r == ST_POS) begin
      pos_r <= POS_W'(y_r[FRAC_BITS-1:0]) * POS_W'(EXP_TABLE_DEPTH);
    end
    if (state_r == ST_RD1) begin
      t0_r <= rom_data;
    end
    if (state_r == ST_SH) begin
      expm1_r <= $signed({1'b0, exp_val}) - ONE_EX;
    end
  end

  // result register: a transfer frees it, a finished item fills it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_act_r <= act_r;
      out_u_r   <= u_r;
      out_ok_r  <= ok_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_activation        = out_act_r;
  assign out_neural_activation = out_u_r;
  assign out_in_range          = out_ok_r;

endmodule
